### src/uisc_pkg.sv
package uisc_pkg;

	localparam int PID_W         = 32;
	localparam int ENTRY_COUNT_W = 4;

	typedef enum logic {
		ACT_ADD    = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_REMOVED   = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		action_t           action;
		logic [PID_W-1:0]  pid;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic [ENTRY_COUNT_W-1:0]  entry_count;
	} rsp_t;

endpackage

### src/uisc_id_ram.sv
module uisc_id_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### src/unique_id_set_compacting_unit.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | uisc_pkg::req_t (action, pid)
// rsp     | out       | rsp_valid/rsp_stall | uisc_pkg::rsp_t (status, entry_count)
//
// One request at a time; a single table read port and one comparator walk the list.
// A request has accept and result steps, with a read and a compare per entry scanned, a
// read and a write per entry shifted down behind a removed match, and an append or tail check.
// arst_n clears the entry count, the sequencer and rsp_valid; table contents need no reset.
// A new request is taken while a finished result still waits under rsp_stall; the next
// result then holds in its result step until that one is taken.
module unique_id_set_compacting_unit #(
	parameter int CAPACITY = 8,
	parameter int ID_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  uisc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output uisc_pkg::rsp_t rsp
);

	import uisc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_APPEND,
		S_SHIFT,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	state_t               state_q;
	action_t              act_q;
	logic [ID_WIDTH-1:0]  id_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     scan_q;
	logic [IDX_W-1:0]     pos_q;
	status_t              res_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ID_WIDTH-1:0]  ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [ID_WIDTH-1:0]  ram_rdata;
	logic [ID_WIDTH-1:0]  req_id;
	logic                 full;

	assign req_id    = ID_WIDTH'(req.pid);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign req_stall = (state_q != S_IDLE);

	// one write port: append at the tail or move an entry down one place
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = ram_rdata;
		ram_raddr = scan_q;
		unique case (state_q)
			S_APPEND: begin
				ram_we    = !full;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = id_q;
			end
			S_SHIFT: begin
				ram_raddr = pos_q + IDX_W'(1);
			end
			S_SHIFT_WR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	uisc_id_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(ID_WIDTH)
	) u_id_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			act_q     <= ACT_ADD;
			id_q      <= '0;
			count_q   <= '0;
			scan_q    <= '0;
			pos_q     <= '0;
			res_q     <= ST_ADDED;
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			// result step loads the output, else hold while stalled
			rsp_valid <= (state_q == S_DONE) || (rsp_valid && rsp_stall);
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						act_q  <= req.action;
						id_q   <= req_id;
						scan_q <= '0;
						priority if (req.action == ACT_ADD && req_id == '0) begin
							res_q   <= ST_DUPLICATE;
							state_q <= S_DONE;
						end else if (req.action == ACT_REMOVE && count_q == '0) begin
							res_q   <= ST_EMPTY;
							state_q <= S_DONE;
						end else if (req.action == ACT_REMOVE && req_id == '0) begin
							res_q   <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							state_q <= S_APPEND;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					priority if (ram_rdata == id_q) begin
						if (act_q == ACT_ADD) begin
							res_q   <= ST_DUPLICATE;
							state_q <= S_DONE;
						end else begin
							pos_q   <= scan_q;
							state_q <= S_SHIFT;
						end
					end else if (CNT_W'(scan_q) + CNT_W'(1) == count_q) begin
						if (act_q == ACT_ADD) begin
							state_q <= S_APPEND;
						end else begin
							res_q   <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end
					end else begin
						scan_q  <= scan_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_APPEND: begin
					if (full) begin
						res_q <= ST_FULL;
					end else begin
						count_q <= count_q + CNT_W'(1);
						res_q   <= ST_ADDED;
					end
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					// pull the next entry down until the tail is reached
					if (CNT_W'(pos_q) + CNT_W'(1) < count_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						res_q   <= (count_q == CNT_W'(1)) ? ST_EMPTY : ST_REMOVED;
						state_q <= S_DONE;
					end
				end
				S_SHIFT_WR: begin
					pos_q   <= pos_q + IDX_W'(1);
					state_q <= S_SHIFT;
				end
				S_DONE: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp.status      <= res_q;
						rsp.entry_count <= ENTRY_COUNT_W'(count_q);
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
